>>> rtl/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// shared opcode codes and default sizes for the sign-magnitude alu
// ----------------------------------------------------------------------------

package sma_pkg;

  localparam int unsigned ValueBits = 31;
  localparam int unsigned ModeBits  = 4;

  typedef enum logic [ModeBits-1:0] {
    OpAnd  = 4'd0,
    OpOr   = 4'd1,
    OpXor  = 4'd2,
    OpAdd  = 4'd3,
    OpSub  = 4'd4,
    OpMul  = 4'd5,
    OpDiv  = 4'd6,
    OpMov  = 4'd7,
    OpNot  = 4'd8,
    OpDec  = 4'd9,
    OpInc  = 4'd10,
    OpIsgn = 4'd11,
    OpSsgn = 4'd12
  } op_e;

endpackage

>>> rtl/sign_magnitude_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_alu
// pipelined alu on sign-magnitude operands (sign 1 is positive)
// ----------------------------------------------------------------------------
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, mode_i, first_sign_i,      | in
//          | first_value_i, second_sign_i, second_value_i       |
//  out     | out_valid_o, out_ready_i, result_sign_o,           | out
//          | result_value_o, overflow_o, divide_by_zero_o       |
//
//  one item per cycle enters while the output is not stalled; the restoring
//  divider computes one quotient bit per stage
//  stage 0 registers the operands, stage 1 holds the product and the
//  add/sub/logic result, then VALUE_BITS divider stages, then the output reg
//  rst_ni clears only the valid bits; payload registers are not reset
//  a stall at the output freezes every stage together, nothing is lost

module sign_magnitude_alu #(
  parameter int unsigned VALUE_BITS = sma_pkg::ValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sma_pkg::ModeBits-1:0]  mode_i,
  input  logic                          first_sign_i,
  input  logic [VALUE_BITS-1:0]         first_value_i,
  input  logic                          second_sign_i,
  input  logic [VALUE_BITS-1:0]         second_value_i,
  // result item
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_sign_o,
  output logic [VALUE_BITS-1:0]         result_value_o,
  output logic                          overflow_o,
  output logic                          divide_by_zero_o
);

  localparam int unsigned NStages = VALUE_BITS + 2;

  typedef logic [VALUE_BITS-1:0] mag_t;

  // payload carried by every stage
  typedef struct packed {
    sma_pkg::op_e              mode;
    logic                      s1;
    logic                      s2;
    mag_t                      m1;
    mag_t                      m2;
    logic                      rsign;    // non mul/div result
    mag_t                      rmag;
    logic                      rovf;
    logic [2*VALUE_BITS-1:0]   prod;
    mag_t                      rem;      // divider partial remainder
    mag_t                      quo;      // dividend shifted out, quotient in
  } stage_t;

  // sign-magnitude add of (sa,ma) and (sb,mb), zero forced positive
  function automatic logic [VALUE_BITS+1:0] sm_add(logic sa, mag_t ma, logic sb, mag_t mb);
    logic [VALUE_BITS:0] sum;
    logic                sgn;
    logic                ovf;
    sum = '0;
    sgn = sa;
    ovf = 1'b0;
    if (sa == sb) begin
      sum = {1'b0, ma} + {1'b0, mb};
      ovf = sum[VALUE_BITS];
    end else if (ma >= mb) begin
      sum = {1'b0, ma - mb};
    end else begin
      sum = {1'b0, mb - ma};
      sgn = sb;
    end
    if (sum[VALUE_BITS-1:0] == '0) begin
      sgn = 1'b1;
    end
    return {ovf, sgn, sum[VALUE_BITS-1:0]};
  endfunction

  stage_t pipe_q [NStages];
  stage_t pipe_d [NStages];
  logic   vld_q  [NStages];
  logic   en;

  logic   out_sign_d, out_ovf_d, out_dz_d;
  mag_t   out_mag_d;
  logic   out_sign_q, out_ovf_q, out_dz_q, out_valid_q;
  mag_t   out_mag_q;

  // whole pipe moves when the output register is free or being drained
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic [VALUE_BITS+1:0] as_res;
    logic [VALUE_BITS:0]   trial;
    logic                  qbit;
    as_res = '0;
    trial  = '0;
    qbit   = 1'b0;

    // stage 0: capture operands
    pipe_d[0]       = pipe_q[0];
    pipe_d[0].mode  = sma_pkg::op_e'(mode_i);
    pipe_d[0].s1    = first_sign_i;
    pipe_d[0].s2    = second_sign_i;
    pipe_d[0].m1    = first_value_i;
    pipe_d[0].m2    = second_value_i;

    // stage 1: product, add/sub and bitwise results, divider seed
    pipe_d[1]       = pipe_q[0];
    pipe_d[1].prod  = {{VALUE_BITS{1'b0}}, pipe_q[0].m1} * {{VALUE_BITS{1'b0}}, pipe_q[0].m2};
    pipe_d[1].rem   = '0;
    pipe_d[1].quo   = pipe_q[0].m1;
    pipe_d[1].rsign = pipe_q[0].s1;
    pipe_d[1].rmag  = pipe_q[0].m1;
    pipe_d[1].rovf  = 1'b0;
    case (pipe_q[0].mode)
      sma_pkg::OpAnd: begin
        pipe_d[1].rsign = pipe_q[0].s1 & pipe_q[0].s2;
        pipe_d[1].rmag  = pipe_q[0].m1 & pipe_q[0].m2;
      end
      sma_pkg::OpOr: begin
        pipe_d[1].rsign = pipe_q[0].s1 | pipe_q[0].s2;
        pipe_d[1].rmag  = pipe_q[0].m1 | pipe_q[0].m2;
      end
      sma_pkg::OpXor: begin
        pipe_d[1].rsign = pipe_q[0].s1 ^ pipe_q[0].s2;
        pipe_d[1].rmag  = pipe_q[0].m1 ^ pipe_q[0].m2;
      end
      sma_pkg::OpAdd: begin
        as_res = sm_add(pipe_q[0].s1, pipe_q[0].m1, pipe_q[0].s2, pipe_q[0].m2);
        {pipe_d[1].rovf, pipe_d[1].rsign, pipe_d[1].rmag} = as_res;
      end
      sma_pkg::OpSub: begin
        as_res = sm_add(pipe_q[0].s1, pipe_q[0].m1, !pipe_q[0].s2, pipe_q[0].m2);
        {pipe_d[1].rovf, pipe_d[1].rsign, pipe_d[1].rmag} = as_res;
      end
      sma_pkg::OpMov: begin
        pipe_d[1].rsign = pipe_q[0].s2;
        pipe_d[1].rmag  = pipe_q[0].m2;
      end
      sma_pkg::OpNot: begin
        pipe_d[1].rsign = !pipe_q[0].s1;
        pipe_d[1].rmag  = ~pipe_q[0].m1;
      end
      // dec and inc are an add of minus one and plus one
      sma_pkg::OpDec: begin
        as_res = sm_add(pipe_q[0].s1, pipe_q[0].m1, 1'b0, mag_t'(1));
        {pipe_d[1].rovf, pipe_d[1].rsign, pipe_d[1].rmag} = as_res;
      end
      sma_pkg::OpInc: begin
        as_res = sm_add(pipe_q[0].s1, pipe_q[0].m1, 1'b1, mag_t'(1));
        {pipe_d[1].rovf, pipe_d[1].rsign, pipe_d[1].rmag} = as_res;
      end
      sma_pkg::OpIsgn: pipe_d[1].rsign = !pipe_q[0].s1;
      sma_pkg::OpSsgn: pipe_d[1].rsign = pipe_q[0].s2;
      default: ;
    endcase

    // restoring divider, one quotient bit per stage
    for (int k = 2; k < NStages; k++) begin
      pipe_d[k] = pipe_q[k-1];
      trial     = {pipe_q[k-1].rem, pipe_q[k-1].quo[VALUE_BITS-1]};
      qbit      = trial >= {1'b0, pipe_q[k-1].m2};
      if (qbit) begin
        trial = trial - {1'b0, pipe_q[k-1].m2};
      end
      pipe_d[k].rem = trial[VALUE_BITS-1:0];
      pipe_d[k].quo = {pipe_q[k-1].quo[VALUE_BITS-2:0], qbit};
    end
  end

  // final select into the output register
  always_comb begin
    stage_t last;
    last       = pipe_q[NStages-1];
    out_sign_d = last.rsign;
    out_mag_d  = last.rmag;
    out_ovf_d  = last.rovf;
    out_dz_d   = 1'b0;
    case (last.mode)
      sma_pkg::OpMul: begin
        out_mag_d  = last.prod[VALUE_BITS-1:0];
        out_ovf_d  = |last.prod[2*VALUE_BITS-1:VALUE_BITS];
        out_sign_d = (last.s1 == last.s2) || (last.prod[VALUE_BITS-1:0] == '0);
      end
      sma_pkg::OpDiv: begin
        out_ovf_d = 1'b0;
        if (last.m2 == '0) begin
          out_mag_d  = '0;
          out_sign_d = 1'b1;
          out_dz_d   = 1'b1;
        end else begin
          out_mag_d  = last.quo;
          out_sign_d = (last.s1 == last.s2) || (last.quo == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStages; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_valid_q <= vld_q[NStages-1];
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NStages; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
      out_sign_q <= out_sign_d;
      out_mag_q  <= out_mag_d;
      out_ovf_q  <= out_ovf_d;
      out_dz_q   <= out_dz_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_sign_o    = out_sign_q;
  assign result_value_o   = out_mag_q;
  assign overflow_o       = out_ovf_q;
  assign divide_by_zero_o = out_dz_q;

endmodule
